[rtl/core/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rlog_pkg.sv]
// ============================================================================
// rlog_pkg
// Types, constants and helpers shared by the record log modules.
// ============================================================================
package rlog_pkg;

   // Geometry. Both counts are powers of two so that addresses wrap naturally.
   localparam int BLOCK_COUNT  = 4;
   localparam int BLOCK_BYTES  = 256;
   localparam int LOG_BYTES    = BLOCK_COUNT * BLOCK_BYTES;
   localparam int ADDR_W       = $clog2(LOG_BYTES);
   localparam int BLK_W        = $clog2(BLOCK_COUNT);
   localparam int OFF_W        = $clog2(BLOCK_BYTES);
   localparam int SPACE_W      = $clog2(BLOCK_BYTES + 1);
   localparam int HEADER_BYTES = 3;
   localparam int MAX_PAYLOAD  = BLOCK_BYTES - HEADER_BYTES;
   localparam int PAY_W        = $clog2(MAX_PAYLOAD + 1);
   localparam int RPB_W        = $clog2(BLOCK_BYTES / 4 + 1);
   localparam int CNT_W        = 9;
   localparam int MAX_RECORDS  = 256;
   localparam int FIFO_DEPTH   = 2;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] START_MARK = 8'hEF;
   localparam logic [7:0] PAD_BYTE   = 8'h20;

   localparam logic CSR_INCLUDE_HEADER = 1'b0;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_READ   = 2'd1,
      MODE_START  = 2'd2,
      MODE_CLEAR  = 2'd3
   } rlog_mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NO_MORE = 3'd1,
      ST_BAD_LEN = 3'd2,
      ST_CORRUPT = 3'd3,
      ST_SEQ_ERR = 3'd4
   } rlog_status_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_PAD,
      B_HDR,
      B_RD_MARK,
      B_RD_LO,
      B_RD_HI,
      B_RD_DATA,
      B_RD_NEXT
   } rlog_bstate_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        first_of_record;
      logic [15:0] record_length;
      logic [7:0]  data_byte;
   } rlog_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  read_byte;
      logic        byte_valid;
      logic        record_end;
      logic [15:0] read_length;
      logic [8:0]  record_count;
   } rlog_rsp_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      rlog_mode_type kind;
      logic          first;
      logic [15:0]   len;
      logic [7:0]    data;
   } rlog_cmd_type;

   function automatic logic [ADDR_W-1:0] blk_base(input logic [BLK_W-1:0] b);
      blk_base = ADDR_W'(b) << OFF_W;
   endfunction

endpackage

[rtl/core/rlog_front.sv]
// ============================================================================
// rlog_front
// Accepts request transactions, classifies them and queues them for the back.
// ============================================================================
module rlog_front import rlog_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rlog_req_type req_payload,
   output logic         cmd_valid,
   output rlog_cmd_type cmd,
   input  logic         cmd_pop
);

   rlog_cmd_type            entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   rlog_cmd_type            classified;
   logic                    push;
   logic                    pop;

   assign req_stall = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      classified.kind  = rlog_mode_type'(req_payload.mode);
      classified.first = req_payload.first_of_record;
      classified.len   = req_payload.record_length;
      classified.data  = req_payload.data_byte;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

[rtl/core/rlog_back.sv]
// ============================================================================
// rlog_back
// Executes queued commands against the log memory and registers each result.
// ============================================================================
module rlog_back import rlog_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         include_header,
   input  logic         cmd_valid,
   input  rlog_cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rlog_rsp_type rsp_payload
);

   logic [7:0]            mem [LOG_BYTES];
   logic [7:0]            rdata_ff;
   logic                  mem_we;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_addr;
   logic [7:0]            mem_wdata;

   rlog_bstate_type       state_ff, state_in;
   rlog_cmd_type          cmd_ff, cmd_in;
   logic [ADDR_W-1:0]     wp_ff, wp_in;
   logic [BLK_W-1:0]      tail_ff, tail_in;
   logic [BLK_W-1:0]      head_ff, head_in;
   logic [SPACE_W-1:0]    space_ff, space_in;
   logic [RPB_W-1:0]      rpb_ff [BLOCK_COUNT];
   logic [RPB_W-1:0]      rpb_in [BLOCK_COUNT];
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [PAY_W-1:0]      abl_ff, abl_in;
   logic [ADDR_W-1:0]     cp_ff, cp_in;
   logic [BLK_W-1:0]      cb_ff, cb_in;
   logic [CNT_W-1:0]      crd_ff, crd_in;
   logic [CNT_W-1:0]      ctot_ff, ctot_in;
   logic [SPACE_W-1:0]    coff_ff, coff_in;
   logic                  armed_ff, armed_in;
   logic [1:0]            hdr_idx_ff, hdr_idx_in;
   logic [7:0]            lo_ff, lo_in;
   logic [PAY_W-1:0]      sz_ff, sz_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rlog_rsp_type          rsp_ff, rsp_in;

   logic                  start;
   logic                  len_bad;
   logic                  fits;
   logic [16:0]           need_c;
   logic                  rd_ok;
   logic                  mark_ok;
   logic [15:0]           sz_rd;
   logic                  sz_bad;
   logic [16:0]           size;
   logic                  off_end;
   logic [ADDR_W:0]       next_full;
   logic [ADDR_W:0]       next_blk_full;
   logic                  next_out;
   logic [BLK_W-1:0]      cb_next;
   logic [BLK_W-1:0]      tail_next;

   logic                  fin;
   logic                  fin_rd;
   rlog_status_type       fin_status;
   logic [7:0]            fin_byte;
   logic                  fin_end;

   // Shared decisions used by both the next-state and the datapath logic.
   always_comb begin
      start         = (state_ff == B_IDLE) && cmd_valid && (!rsp_valid_ff || !rsp_stall);
      need_c        = 17'(cmd.len) + 17'(HEADER_BYTES);
      len_bad       = (cmd.len == 16'd0) || (cmd.len > 16'(MAX_PAYLOAD));
      fits          = need_c <= 17'(space_ff);
      rd_ok         = armed_ff && (crd_ff < ctot_ff);
      mark_ok       = (rdata_ff == START_MARK);
      sz_rd         = {rdata_ff, lo_ff};
      sz_bad        = (sz_rd == 16'd0) || (sz_rd > 16'(MAX_PAYLOAD));
      size          = 17'(sz_ff) + (include_header ? 17'(HEADER_BYTES) : 17'd0);
      off_end       = (17'(coff_ff) + 17'd1) >= size;
      next_full     = (ADDR_W+1)'(cp_ff) + (ADDR_W+1)'(HEADER_BYTES) + (ADDR_W+1)'(sz_ff);
      next_blk_full = ((ADDR_W+1)'(cb_ff) + (ADDR_W+1)'(1)) << OFF_W;
      next_out      = next_full >= next_blk_full;
      cb_next       = cb_ff + BLK_W'(1);
      tail_next     = tail_ff + BLK_W'(1);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (start) begin
               case (cmd.kind)
                  MODE_APPEND: begin
                     if (cmd.first && (abl_ff == '0) && !len_bad) begin
                        state_in = fits ? B_HDR : B_PAD;
                     end
                  end
                  MODE_READ: begin
                     if (rd_ok) begin
                        state_in = B_RD_MARK;
                     end
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_PAD:     state_in = (space_ff == '0) ? B_HDR : B_PAD;
         B_HDR:     state_in = (hdr_idx_ff == 2'd3) ? B_IDLE : B_HDR;
         B_RD_MARK: state_in = mark_ok ? B_RD_LO : B_IDLE;
         B_RD_LO:   state_in = B_RD_HI;
         B_RD_HI:   state_in = sz_bad ? B_IDLE : B_RD_DATA;
         B_RD_DATA: state_in = (off_end && !next_out) ? B_RD_NEXT : B_IDLE;
         B_RD_NEXT: state_in = B_IDLE;
         default:   state_in = B_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = wp_ff;
      mem_wdata  = PAD_BYTE;
      cmd_in     = cmd_ff;
      wp_in      = wp_ff;
      tail_in    = tail_ff;
      head_in    = head_ff;
      space_in   = space_ff;
      rpb_in     = rpb_ff;
      total_in   = total_ff;
      abl_in     = abl_ff;
      cp_in      = cp_ff;
      cb_in      = cb_ff;
      crd_in     = crd_ff;
      ctot_in    = ctot_ff;
      coff_in    = coff_ff;
      armed_in   = armed_ff;
      hdr_idx_in = hdr_idx_ff;
      lo_in      = lo_ff;
      sz_in      = sz_ff;
      byte_in    = byte_ff;
      fin        = 1'b0;
      fin_rd     = 1'b0;
      fin_status = ST_OK;
      fin_byte   = 8'd0;
      fin_end    = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (start) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               case (cmd.kind)
                  MODE_APPEND: begin
                     if (!cmd.first) begin
                        fin = 1'b1;
                        if (abl_ff == '0) begin
                           fin_status = ST_SEQ_ERR;
                        end else begin
                           mem_we    = 1'b1;
                           mem_addr  = wp_ff;
                           mem_wdata = cmd.data;
                           wp_in     = wp_ff + ADDR_W'(1);
                           abl_in    = abl_ff - PAY_W'(1);
                        end
                     end else if (abl_ff != '0) begin
                        fin        = 1'b1;
                        fin_status = ST_SEQ_ERR;
                     end else if (len_bad) begin
                        fin        = 1'b1;
                        fin_status = ST_BAD_LEN;
                     end else begin
                        hdr_idx_in = 2'd0;
                     end
                  end
                  MODE_READ: begin
                     if (!armed_ff) begin
                        fin        = 1'b1;
                        fin_status = ST_SEQ_ERR;
                     end else if (!rd_ok) begin
                        fin        = 1'b1;
                        fin_status = ST_NO_MORE;
                     end else begin
                        mem_re   = 1'b1;
                        mem_addr = cp_ff;
                     end
                  end
                  MODE_START: begin
                     fin      = 1'b1;
                     cp_in    = blk_base(head_ff);
                     cb_in    = head_ff;
                     crd_in   = '0;
                     ctot_in  = total_ff;
                     coff_in  = '0;
                     armed_in = 1'b1;
                  end
                  default: begin
                     fin      = 1'b1;
                     wp_in    = '0;
                     tail_in  = '0;
                     head_in  = '0;
                     space_in = SPACE_W'(BLOCK_BYTES);
                     for (int i = 0; i < BLOCK_COUNT; i++) begin
                        rpb_in[i] = '0;
                     end
                     total_in = '0;
                     abl_in   = '0;
                     cp_in    = '0;
                     cb_in    = '0;
                     crd_in   = '0;
                     ctot_in  = '0;
                     coff_in  = '0;
                     armed_in = 1'b0;
                  end
               endcase
            end
         end

         B_PAD: begin
            if (space_ff != '0) begin
               mem_we    = 1'b1;
               mem_addr  = wp_ff;
               mem_wdata = PAD_BYTE;
               wp_in     = wp_ff + ADDR_W'(1);
               space_in  = space_ff - SPACE_W'(1);
            end else begin
               // Move to the next block; evict it if it holds the oldest data.
               tail_in           = tail_next;
               wp_in             = blk_base(tail_next);
               space_in          = SPACE_W'(BLOCK_BYTES);
               total_in          = total_ff - CNT_W'(rpb_ff[tail_next]);
               rpb_in[tail_next] = '0;
               if (head_ff == tail_next) begin
                  head_in = head_ff + BLK_W'(1);
               end
            end
         end

         B_HDR: begin
            mem_we     = 1'b1;
            mem_addr   = wp_ff + ADDR_W'(hdr_idx_ff);
            hdr_idx_in = hdr_idx_ff + 2'd1;
            case (hdr_idx_ff)
               2'd0:    mem_wdata = START_MARK;
               2'd1:    mem_wdata = cmd_ff.len[7:0];
               2'd2:    mem_wdata = cmd_ff.len[15:8];
               default: mem_wdata = cmd_ff.data;
            endcase
            if (hdr_idx_ff == 2'd3) begin
               fin             = 1'b1;
               wp_in           = wp_ff + ADDR_W'(4);
               space_in        = space_ff -
                                 SPACE_W'(17'(cmd_ff.len) + 17'(HEADER_BYTES));
               rpb_in[tail_ff] = rpb_ff[tail_ff] + RPB_W'(1);
               total_in        = total_ff + CNT_W'(1);
               abl_in          = PAY_W'(cmd_ff.len - 16'd1);
            end
         end

         B_RD_MARK: begin
            if (!mark_ok) begin
               fin        = 1'b1;
               fin_status = ST_CORRUPT;
            end else begin
               mem_re   = 1'b1;
               mem_addr = cp_ff + ADDR_W'(1);
            end
         end

         B_RD_LO: begin
            lo_in    = rdata_ff;
            mem_re   = 1'b1;
            mem_addr = cp_ff + ADDR_W'(2);
         end

         B_RD_HI: begin
            if (sz_bad) begin
               fin        = 1'b1;
               fin_status = ST_BAD_LEN;
            end else begin
               sz_in    = sz_rd[PAY_W-1:0];
               mem_re   = 1'b1;
               mem_addr = (include_header ? cp_ff : cp_ff + ADDR_W'(HEADER_BYTES)) +
                          ADDR_W'(coff_ff);
            end
         end

         B_RD_DATA: begin
            byte_in = rdata_ff;
            if (!off_end) begin
               fin      = 1'b1;
               fin_rd   = 1'b1;
               fin_byte = rdata_ff;
               coff_in  = coff_ff + SPACE_W'(1);
            end else if (next_out) begin
               fin      = 1'b1;
               fin_rd   = 1'b1;
               fin_byte = rdata_ff;
               fin_end  = 1'b1;
               cb_in    = cb_next;
               cp_in    = blk_base(cb_next);
               crd_in   = crd_ff + CNT_W'(1);
               coff_in  = '0;
            end else begin
               mem_re   = 1'b1;
               mem_addr = next_full[ADDR_W-1:0];
            end
         end

         B_RD_NEXT: begin
            fin      = 1'b1;
            fin_rd   = 1'b1;
            fin_byte = byte_ff;
            fin_end  = 1'b1;
            if (mark_ok) begin
               cp_in = next_full[ADDR_W-1:0];
            end else begin
               cb_in = cb_next;
               cp_in = blk_base(cb_next);
            end
            crd_in  = crd_ff + CNT_W'(1);
            coff_in = '0;
         end

         default: begin
            fin = 1'b0;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (fin) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = fin_status;
         rsp_in.read_byte    = fin_rd ? fin_byte : 8'd0;
         rsp_in.byte_valid   = fin_rd;
         rsp_in.record_end   = fin_rd && fin_end;
         rsp_in.read_length  = fin_rd ? size[15:0] : 16'd0;
         rsp_in.record_count = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wp_ff        <= '0;
         tail_ff      <= '0;
         head_ff      <= '0;
         space_ff     <= SPACE_W'(BLOCK_BYTES);
         for (int i = 0; i < BLOCK_COUNT; i++) begin
            rpb_ff[i] <= '0;
         end
         total_ff     <= '0;
         abl_ff       <= '0;
         cp_ff        <= '0;
         cb_ff        <= '0;
         crd_ff       <= '0;
         ctot_ff      <= '0;
         coff_ff      <= '0;
         armed_ff     <= 1'b0;
         hdr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         tail_ff      <= tail_in;
         head_ff      <= head_in;
         space_ff     <= space_in;
         rpb_ff       <= rpb_in;
         total_ff     <= total_in;
         abl_ff       <= abl_in;
         cp_ff        <= cp_in;
         cb_ff        <= cb_in;
         crd_ff       <= crd_in;
         ctot_ff      <= ctot_in;
         coff_ff      <= coff_in;
         armed_ff     <= armed_in;
         hdr_idx_ff   <= hdr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      lo_ff   <= lo_in;
      sz_ff   <= sz_in;
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
   end

   // Single-port byte memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[rtl/core/block_ring_record_log.sv]
// ============================================================================
// block_ring_record_log
// Ring log of variable-length records in a block-organized byte memory.
// ============================================================================
// The log is a 1024-byte single-port memory split into four 256-byte blocks.
// Each record is stored as a 0xEF start mark, a two-byte little-endian length
// and its payload. Every request transaction produces exactly one response
// transaction. Timing is set by the single memory port, which moves one byte
// per cycle. A follow-on append byte, a read start, a clear or any rejected
// request finishes in the back end's idle state. A first append byte that does
// not fit pads the block (up to 252 bytes) and moves on, then writes the mark,
// both length bytes and the data byte. A read byte reads the header and the
// data byte, and the next mark when it closes a record whose successor lies
// in the same block. Memory is not cleared after reset, so there is no startup
// pass; never-written bytes read as whatever the memory holds.
// ============================================================================
module block_ring_record_log import rlog_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_valid,
   output logic         req_stall,
   input  rlog_req_type req_payload,
   // Response channel.
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rlog_rsp_type rsp_payload,
   // Register port.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic         include_header_ff, include_header_in;
   logic         csr_write;
   logic         cmd_valid;
   logic         cmd_pop;
   rlog_cmd_type cmd;

   // The only register sits at byte address 0; the word index is paddr[2].
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_INCLUDE_HEADER);
   assign csr_prdata = (csr_paddr[2] == CSR_INCLUDE_HEADER) ? 32'(include_header_ff) : 32'd0;

   always_comb begin
      include_header_in = csr_write ? csr_pwdata[0] : include_header_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         include_header_ff <= 1'b0;
      end else begin
         include_header_ff <= include_header_in;
      end
   end

   // The front end buffers and classifies transactions so that requests can still
   // be taken, until its two entries are full, while the back end works through memory cycles.
   rlog_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   // The back end owns the memory, the log pointers and the read cursor, and
   // holds each result in an output register until it is taken.
   rlog_back u_back (
      .clock          (clock),
      .reset          (reset),
      .include_header (include_header_ff),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

endmodule

[rtl/core/rlog_checker.sv]
// ============================================================================
// rlog_checker
// Port-level checks on the record log responses.
// ============================================================================
`include "assert_macros.svh"

module rlog_checker import rlog_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rlog_rsp_type rsp_payload
);

   `CHK_NEXT(a_rsp_hold, clock, reset,
             rsp_valid && rsp_stall,
             rsp_valid && $stable(rsp_payload),
             "stalled response changed")

   `CHK_SAME(a_byte_ok, clock, reset,
             rsp_valid && rsp_payload.byte_valid,
             rsp_payload.status == ST_OK && rsp_payload.read_length != 16'd0,
             "read byte without ok status")

   `CHK_SAME(a_err_clean, clock, reset,
             rsp_valid && rsp_payload.status != ST_OK,
             !rsp_payload.byte_valid && !rsp_payload.record_end &&
             rsp_payload.read_length == 16'd0,
             "error response carries data")

   `CHK_SAME(a_count_max, clock, reset,
             rsp_valid,
             rsp_payload.record_count <= 9'(MAX_RECORDS),
             "record count out of range")

endmodule

bind block_ring_record_log rlog_checker u_rlog_checker (.*);

[tb/sv/tb_block_ring_record_log.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_block_ring_record_log
// Self-checking testbench for the block-organized ring log of records.
// ============================================================================
// Request transactions are driven at the falling edge and responses are
// sampled at the rising edge. Every accepted request is run through a
// behavioral model of the log kept here. The model holds its own memory
// image, write side, read cursor and header setting, and it queues the
// response that the request must produce. A directed table comes first and
// covers the length limits, out-of-order appends, an exact block fill and a
// full read-back. Random phases follow, each under its own header setting.
// Both sides of the block idle at random, and the response side holds off
// once for a long stretch so that the block fills up and stalls requests.
// ============================================================================
module tb_block_ring_record_log;
   import rlog_pkg::*;

   localparam logic [2:0] CSR_ADDR_INCLUDE_HEADER = 3'd0;
   localparam int         RANDOM_ITEMS            = 432;
   localparam int         RANDOM_PHASES           = 4;
   localparam int         REQ_W                   = $bits(rlog_req_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   rlog_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rlog_rsp_type rsp_payload;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   block_ring_record_log dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Behavioral model of the log. The written flags track which bytes have
   // been stored since reset, so that the stimulus never reads a byte whose
   // contents are undefined.
   // -------------------------------------------------------------------------
   logic [7:0]  log_image [LOG_BYTES];
   bit          log_written [LOG_BYTES];
   int unsigned wr_ptr, tail_idx, head_idx, space_left, bytes_owed;
   int unsigned blk_records [BLOCK_COUNT];
   int unsigned cur_ptr, cur_blk, cur_done, cur_total, cur_off;
   bit          cur_armed;
   bit          header_on;

   rlog_rsp_type owed_responses [$];
   int           error_count = 0;
   int           rsp_seen = 0;

   function automatic void image_put(int unsigned addr, logic [7:0] value);
      log_image[addr % LOG_BYTES]   = value;
      log_written[addr % LOG_BYTES] = 1'b1;
   endfunction

   function automatic logic [7:0] image_get(int unsigned addr);
      return log_image[addr % LOG_BYTES];
   endfunction

   function automatic bit image_known(int unsigned addr);
      return log_written[addr % LOG_BYTES];
   endfunction

   function automatic int unsigned records_held();
      int unsigned sum;
      sum = 0;
      foreach (blk_records[i]) sum += blk_records[i];
      return sum;
   endfunction

   function automatic void log_reset_state();
      foreach (log_written[i]) begin
         log_written[i] = 1'b0;
         log_image[i]   = 8'h00;
      end
      header_on = 1'b0;
      wr_ptr = 0; tail_idx = 0; head_idx = 0;
      space_left = BLOCK_BYTES; bytes_owed = 0;
      foreach (blk_records[i]) blk_records[i] = 0;
      cur_ptr = 0; cur_blk = 0; cur_done = 0; cur_total = 0; cur_off = 0;
      cur_armed = 1'b0;
   endfunction

   // Tells whether a read issued now would touch only bytes already written.
   // It follows the same accesses as the read itself, including the look at
   // the byte after a record that is being closed.
   function automatic bit read_touches_known();
      int unsigned sz, size, base, next;
      if (!cur_armed || cur_done >= cur_total) return 1'b1;
      if (!image_known(cur_ptr)) return 1'b0;
      if (image_get(cur_ptr) != START_MARK) return 1'b1;
      if (!image_known(cur_ptr + 1) || !image_known(cur_ptr + 2)) return 1'b0;
      sz = 32'({image_get(cur_ptr + 2), image_get(cur_ptr + 1)});
      if (sz == 0 || sz > MAX_PAYLOAD) return 1'b1;
      size = sz + (header_on ? HEADER_BYTES : 0);
      base = header_on ? cur_ptr : cur_ptr + HEADER_BYTES;
      if (!image_known(base + cur_off)) return 1'b0;
      if (cur_off + 1 >= size) begin
         next = cur_ptr + HEADER_BYTES + sz;
         if (next < (cur_blk + 1) * BLOCK_BYTES && !image_known(next)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic rlog_status_type append_byte(logic first, int unsigned len,
                                                   logic [7:0] data);
      int unsigned need;
      if (!first) begin
         if (bytes_owed == 0) return ST_SEQ_ERR;
         image_put(wr_ptr, data);
         wr_ptr++;
         bytes_owed--;
         return ST_OK;
      end
      if (bytes_owed != 0) return ST_SEQ_ERR;
      if (len == 0 || len > MAX_PAYLOAD) return ST_BAD_LEN;
      need = len + HEADER_BYTES;
      if (need > space_left) begin
         // The rest of the tail block is padded and writing moves on,
         // evicting the oldest block when the ring has wrapped onto it.
         for (int unsigned i = 0; i < space_left; i++) image_put(wr_ptr + i, PAD_BYTE);
         tail_idx   = (tail_idx + 1) % BLOCK_COUNT;
         wr_ptr     = tail_idx * BLOCK_BYTES;
         space_left = BLOCK_BYTES;
         blk_records[tail_idx] = 0;
         if (head_idx == tail_idx) head_idx = (head_idx + 1) % BLOCK_COUNT;
      end
      image_put(wr_ptr, START_MARK);
      image_put(wr_ptr + 1, len[7:0]);
      image_put(wr_ptr + 2, len[15:8]);
      image_put(wr_ptr + 3, data);
      wr_ptr     += 4;
      space_left -= need;
      blk_records[tail_idx]++;
      bytes_owed = len - 1;
      return ST_OK;
   endfunction

   function automatic rlog_status_type read_byte_out(ref rlog_rsp_type r);
      int unsigned sz, size, base, next;
      if (!cur_armed) return ST_SEQ_ERR;
      if (cur_done >= cur_total) return ST_NO_MORE;
      if (image_get(cur_ptr) != START_MARK) return ST_CORRUPT;
      sz = 32'({image_get(cur_ptr + 2), image_get(cur_ptr + 1)});
      if (sz == 0 || sz > MAX_PAYLOAD) return ST_BAD_LEN;
      // The record size follows the header setting in force at this byte.
      size = sz + (header_on ? HEADER_BYTES : 0);
      base = header_on ? cur_ptr : cur_ptr + HEADER_BYTES;
      r.read_byte   = image_get(base + cur_off);
      r.byte_valid  = 1'b1;
      r.read_length = size[15:0];
      if (cur_off + 1 >= size) begin
         r.record_end = 1'b1;
         next = cur_ptr + HEADER_BYTES + sz;
         if (next >= (cur_blk + 1) * BLOCK_BYTES || image_get(next) != START_MARK) begin
            cur_blk = (cur_blk + 1) % BLOCK_COUNT;
            cur_ptr = cur_blk * BLOCK_BYTES;
         end else begin
            cur_ptr = next;
         end
         cur_done++;
         cur_off = 0;
      end else begin
         cur_off++;
      end
      return ST_OK;
   endfunction

   // Advances the model by one request and returns the response it implies.
   function automatic rlog_rsp_type ring_log_step(rlog_req_type q);
      rlog_rsp_type    r;
      rlog_status_type st;
      r  = '0;
      st = ST_OK;
      case (rlog_mode_type'(q.mode))
         MODE_APPEND: begin
            st = append_byte(q.first_of_record, q.record_length, q.data_byte);
         end
         MODE_READ: begin
            st = read_byte_out(r);
         end
         MODE_START: begin
            cur_ptr   = head_idx * BLOCK_BYTES;
            cur_blk   = head_idx;
            cur_done  = 0;
            cur_total = records_held();
            cur_off   = 0;
            cur_armed = 1'b1;
         end
         default: begin
            wr_ptr = 0; tail_idx = 0; head_idx = 0;
            space_left = BLOCK_BYTES; bytes_owed = 0;
            foreach (blk_records[i]) blk_records[i] = 0;
            cur_ptr = 0; cur_blk = 0; cur_done = 0; cur_total = 0; cur_off = 0;
            cur_armed = 1'b0;
         end
      endcase
      r.status       = st;
      r.record_count = 9'(records_held());
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Checking of response transactions.
   // -------------------------------------------------------------------------
   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s, got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rlog_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (owed_responses.size() == 0) begin
            report("unexpected response", 32'(rsp_payload), 32'd0);
         end else begin
            want = owed_responses.pop_front();
            if (rsp_payload.status !== want.status)
               report("status", 32'(rsp_payload.status), 32'(want.status));
            if (rsp_payload.read_byte !== want.read_byte)
               report("read_byte", 32'(rsp_payload.read_byte), 32'(want.read_byte));
            if (rsp_payload.byte_valid !== want.byte_valid)
               report("byte_valid", 32'(rsp_payload.byte_valid), 32'(want.byte_valid));
            if (rsp_payload.record_end !== want.record_end)
               report("record_end", 32'(rsp_payload.record_end), 32'(want.record_end));
            if (rsp_payload.read_length !== want.read_length)
               report("read_length", 32'(rsp_payload.read_length),
                      32'(want.read_length));
            if (rsp_payload.record_count !== want.record_count)
               report("record_count", 32'(rsp_payload.record_count),
                      32'(want.record_count));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response side stalling. Stretches run free, stall briefly or stall for a
   // while. Once, after 200 responses, the receiver holds off while requests
   // keep coming, so the block backs up.
   // -------------------------------------------------------------------------
   int hold_left = 0, stall_left = 0, free_left = 0;
   bit hold_done = 1'b0;

   always @(negedge clock) begin
      int pick;
      if (!hold_done && rsp_seen >= 200) begin
         hold_done = 1'b1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 10) free_left = $urandom_range(50, 200);
         else if (pick < 60) free_left = $urandom_range(0, 4);
         else if (pick < 95) stall_left = $urandom_range(1, 3);
         else stall_left = $urandom_range(15, 60);
         rsp_stall <= 1'b0;
      end
   end

   // -------------------------------------------------------------------------
   // Request side. A gap of idle cycles may come ahead of each transaction;
   // in steady phases there are none.
   // -------------------------------------------------------------------------
   bit sender_steady = 1'b0;

   function automatic int idle_gap();
      int pick;
      if (sender_steady) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      if (pick < 99) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Queues the expected response, then offers the transaction until taken.
   task automatic send_request(rlog_req_type q, bit typed, rlog_rsp_type typed_rsp);
      rlog_rsp_type modeled;
      int           gap;
      modeled = ring_log_step(q);
      owed_responses.push_back(typed ? typed_rsp : modeled);
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= q;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (owed_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == CSR_ADDR_INCLUDE_HEADER) header_on = value[0];
   endtask

   // -------------------------------------------------------------------------
   // Directed table. A row may repeat its request; rows with a typed response
   // are checked against that, all others against the model.
   // -------------------------------------------------------------------------
   typedef struct {
      rlog_req_type req;
      int           reps;
      bit           typed;
      rlog_rsp_type want;
   } table_row_type;

   table_row_type plan [$];

   function automatic void add_row(rlog_mode_type m, logic first, logic [15:0] len,
                                   logic [7:0] data, int reps, bit typed,
                                   rlog_status_type st, logic [8:0] count);
      table_row_type row;
      row.req = '{mode: m, first_of_record: first, record_length: len, data_byte: data};
      row.reps = reps;
      row.typed = typed;
      row.want = '0;
      row.want.status = st;
      row.want.record_count = count;
      plan.push_back(row);
   endfunction

   // -------------------------------------------------------------------------
   // Random part. Mostly well-formed records, start/read runs and the odd
   // clear, with some noise transactions and abandoned records mixed in.
   // -------------------------------------------------------------------------
   task automatic random_phase(int items);
      rlog_req_type q;
      int           sent, pick, len, burst;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         q = REQ_W'($urandom);
         if (pick < 45) begin
            case ($urandom_range(0, 99)) inside
               [0:69]:  len = $urandom_range(1, 12);
               [70:89]: len = $urandom_range(13, 80);
               [90:96]: len = $urandom_range(81, MAX_PAYLOAD);
               default: len = ($urandom_range(0, 1) == 0) ? 0
                              : $urandom_range(MAX_PAYLOAD + 1, 65535);
            endcase
            q.mode = MODE_APPEND;
            q.first_of_record = 1'b1;
            q.record_length = 16'(len);
            send_request(q, 1'b0, '0);
            sent++;
            for (int i = 1; i < len && len <= MAX_PAYLOAD; i++) begin
               if ($urandom_range(0, 299) == 0) break;
               q = REQ_W'($urandom);
               q.mode = MODE_APPEND;
               q.first_of_record = 1'b0;
               send_request(q, 1'b0, '0);
               sent++;
            end
         end else if (pick < 60) begin
            q.mode = MODE_START;
            send_request(q, 1'b0, '0);
            sent++;
         end else if (pick < 88) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst; i++) begin
               if (!read_touches_known()) break;
               q = REQ_W'($urandom);
               q.mode = MODE_READ;
               send_request(q, 1'b0, '0);
               sent++;
            end
         end else if (pick < 91) begin
            q.mode = MODE_CLEAR;
            send_request(q, 1'b0, '0);
            sent++;
         end else if (q.mode != MODE_READ || read_touches_known()) begin
            send_request(q, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      log_reset_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(CSR_ADDR_INCLUDE_HEADER, 32'd0);

      // Error cases on an empty log first, then an exact fill of block 0 by a
      // maximum record with an out-of-order first byte in the middle of its
      // payload. A full read-back follows; the closing byte of the record
      // sends the cursor on to the next block without a look past the end.
      add_row(MODE_READ,   1'b0, 16'd0,    8'h00, 1,   1'b1, ST_SEQ_ERR, 9'd0);
      add_row(MODE_APPEND, 1'b0, 16'd0,    8'h11, 1,   1'b1, ST_SEQ_ERR, 9'd0);
      add_row(MODE_APPEND, 1'b1, 16'd0,    8'h22, 1,   1'b1, ST_BAD_LEN, 9'd0);
      add_row(MODE_APPEND, 1'b1, 16'd254,  8'h33, 1,   1'b1, ST_BAD_LEN, 9'd0);
      add_row(MODE_APPEND, 1'b1, 16'hFFFF, 8'hFF, 1,   1'b1, ST_BAD_LEN, 9'd0);
      add_row(MODE_APPEND, 1'b1, 16'd253,  8'h00, 1,   1'b1, ST_OK,      9'd1);
      add_row(MODE_APPEND, 1'b0, 16'd0,    8'hFF, 100, 1'b0, ST_OK,      9'd0);
      add_row(MODE_APPEND, 1'b1, 16'd5,    8'h55, 1,   1'b1, ST_SEQ_ERR, 9'd1);
      add_row(MODE_APPEND, 1'b0, 16'hFFFF, 8'h80, 152, 1'b0, ST_OK,      9'd0);
      add_row(MODE_START,  1'b0, 16'd0,    8'h00, 1,   1'b1, ST_OK,      9'd1);
      add_row(MODE_READ,   1'b0, 16'd0,    8'h00, 253, 1'b0, ST_OK,      9'd0);
      add_row(MODE_READ,   1'b0, 16'd0,    8'h00, 1,   1'b1, ST_NO_MORE, 9'd1);
      add_row(MODE_CLEAR,  1'b0, 16'd0,    8'h00, 1,   1'b1, ST_OK,      9'd0);
      add_row(MODE_READ,   1'b0, 16'd0,    8'h00, 1,   1'b1, ST_SEQ_ERR, 9'd0);

      foreach (plan[i])
         for (int k = 0; k < plan[i].reps; k++)
            send_request(plan[i].req, plan[i].typed, plan[i].want);
      sender_idle();
      wait_drained();

      // Random phases alternate the header setting. The cursor may be left
      // mid-record at a boundary, so a record can end under a changed setting.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         csr_write(CSR_ADDR_INCLUDE_HEADER, (p % 2 == 0) ? 32'd1 : 32'd0);
         sender_steady = (p == 2);
         random_phase(RANDOM_ITEMS / RANDOM_PHASES);
         sender_idle();
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
